FILE: hw/rtl/ilsa_pkg.sv
// Shared constants for the lowest-free-slot interval assignment block.
// No dependencies; imported by every module of the block but ilsa_mem.
package ilsa_pkg;

	// Default number of physical slots and width of a time value.
	localparam int SLOTS_DEF     = 64;
	localparam int TIME_BITS_DEF = 32;

	// Width of the usable-slot register and of the reported slot number.
	localparam int CFG_W = 7;
	localparam int IDX_W = 7;

	// Usable-slot register value after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

endpackage

FILE: hw/rtl/ilsa_mem.sv
// Slot memory: one write port, one read port, read data registered.
// Depends on nothing but its parameters.
module ilsa_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Synchronous write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Synchronous read: the data for a read address is registered and appears in the next cycle.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/ilsa_ctrl.sv
// Sweep sequencer: clears the slot memory after reset, then for each interval
// reads every slot, frees expired ones, commits the lowest free usable one if any.
// Depends on ilsa_pkg; drives the ports of ilsa_mem.
module ilsa_ctrl #(
	parameter int SLOTS     = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [TIME_BITS-1:0]           start_time,
	input  logic [TIME_BITS-1:0]           finish_time,
	input  logic [$clog2(SLOTS+1)-1:0]     usable,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ilsa_pkg::IDX_W-1:0]     slot_index,
	output logic                           full_res,
	output logic                           mem_we,
	output logic [$clog2(SLOTS)-1:0]       mem_waddr,
	output logic [TIME_BITS:0]             mem_wdata,
	output logic                           mem_re,
	output logic [$clog2(SLOTS)-1:0]       mem_raddr,
	input  logic [TIME_BITS:0]             mem_rdata
);
	import ilsa_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        rd_cnt_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        addr_s1;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] finish_q;
	logic [CW-1:0]        usable_q;
	logic                 found_q;
	logic [AW-1:0]        chosen_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     slot_index_q;
	logic                 full_q;

	logic                 busy_s1;
	logic [TIME_BITS-1:0] fin_s1;
	logic                 expire_s1;
	logic                 free_s1;
	logic                 in_range_s1;
	logic                 out_free;
	logic                 rd_more;
	logic [SW-1:0]        slot_num;

	// Decode the entry returned by the memory this cycle.
	assign busy_s1     = mem_rdata[TIME_BITS];
	assign fin_s1      = mem_rdata[TIME_BITS-1:0];
	assign expire_s1   = busy_s1 && (fin_s1 < start_q);
	assign free_s1     = !busy_s1 || expire_s1;
	assign in_range_s1 = CW'(addr_s1) < usable_q;

	assign out_free = !out_valid_q || !out_stall;
	assign rd_more  = rd_cnt_q < CW'(SLOTS);
	assign slot_num = SW'(chosen_q) + SW'(1);

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign slot_index = slot_index_q;
	assign full_res   = full_q;

	// Read port walks the slots in order during a sweep.
	assign mem_re    = (state_q == ST_SWEEP) && rd_more;
	assign mem_raddr = rd_cnt_q[AW-1:0];

	// Write port: clearing pass, freeing of expired slots, final commit.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_SWEEP: begin
				mem_we    = rd_vld_s1 && expire_s1;
				mem_waddr = addr_s1;
				mem_wdata = {1'b0, fin_s1};
			end
			ST_DONE: begin
				mem_we    = found_q && out_free;
				mem_waddr = chosen_q;
				mem_wdata = {1'b1, finish_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						state_q  <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (rd_more) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (rd_vld_s1 && free_s1 && in_range_s1 && !found_q) begin
						found_q <= 1'b1;
					end
					if (!rd_more && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Interval payload and the chosen slot.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			start_q  <= start_time;
			finish_q <= finish_time;
			usable_q <= usable;
		end
		if (state_q == ST_SWEEP && rd_vld_s1) begin
			addr_s1 <= addr_s1 + AW'(1);
		end else if (state_q != ST_SWEEP) begin
			addr_s1 <= '0;
		end
		if (state_q == ST_SWEEP && rd_vld_s1 && free_s1 && in_range_s1 && !found_q) begin
			chosen_q <= addr_s1;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			slot_index_q <= found_q ? slot_num[IDX_W-1:0] : '0;
			full_q       <= !found_q;
		end
	end

endmodule

FILE: hw/rtl/interval_lowest_slot_assign_unit.sv
// Each accepted interval is a sweep of the slot memory through its single read port, one slot
// a cycle. The sweep frees slots whose end time is earlier than the new begin time, then writes
// the end time into the lowest free usable slot, if there is one, and presents the word. No new
// interval is taken until the sequencer is idle again. A stalled output word holds the sequencer
// in its final step until the word leaves. After reset a clearing pass marks all slots free;
// input is stalled during it while configuration writes are taken. The usable-slot count is
// clamped to SLOTS, and a value of zero rejects every interval.
// Depends on ilsa_pkg, ilsa_mem and ilsa_ctrl.
module interval_lowest_slot_assign_unit #(
	parameter int SLOTS     = ilsa_pkg::SLOTS_DEF,
	parameter int TIME_BITS = ilsa_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ilsa_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [TIME_BITS-1:0]       start_time,
	input  logic [TIME_BITS-1:0]       finish_time,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ilsa_pkg::IDX_W-1:0] slot_index,
	output logic                       full_res
);
	import ilsa_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int UW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0]     slots_cfg_q;
	logic [CW-1:0]        usable;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [TIME_BITS:0]   mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [TIME_BITS:0]   mem_rdata;

	// Usable-slot register, always ready for a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			slots_cfg_q <= cfg_data;
		end
	end

	// Clamp the usable count to the number of physical slots.
	assign usable = (UW'(slots_cfg_q) > UW'(SLOTS)) ? CW'(SLOTS) : CW'(slots_cfg_q);

	ilsa_ctrl #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_time  (start_time),
		.finish_time (finish_time),
		.usable      (usable),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.slot_index  (slot_index),
		.full_res    (full_res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// Each entry holds a busy flag above the recorded end time.
	ilsa_mem #(
		.DEPTH (SLOTS),
		.WIDTH (TIME_BITS + 1)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

FILE: hw/rtl/ilsa_chk.sv
// Port-level checker for the interval slot assignment block, bound to its top level.
// Depends on ilsa_pkg.
module ilsa_chk #(
	parameter int SLOTS     = ilsa_pkg::SLOTS_DEF,
	parameter int TIME_BITS = ilsa_pkg::TIME_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [ilsa_pkg::IDX_W-1:0] slot_index,
	input logic                       full_res
);
	import ilsa_pkg::*;

	// A rejected interval always reports slot zero.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_res |-> slot_index == '0)
		else $error("full word carries a nonzero slot number");

	// An accepted slot is numbered from one when the number fits the field.
	a_slot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !full_res && (SLOTS < (1 << IDX_W)) |-> slot_index != '0)
		else $error("accepted interval reports slot zero");

	// The block works on one interval at a time: input stalls after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again in the cycle after an accept");

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_index) && $stable(full_res))
		else $error("stalled output word changed");

endmodule

bind interval_lowest_slot_assign_unit ilsa_chk #(
	.SLOTS     (SLOTS),
	.TIME_BITS (TIME_BITS)
) u_ilsa_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.slot_index (slot_index),
	.full_res   (full_res)
);
